### design/hsp_pkg.sv
// hsp_pkg: shared types, byte codes and helper functions for the HTTP
// start-line / header parser. No dependencies; imported by every module.
package hsp_pkg;

    localparam int unsigned RES_SLOTS     = 3;  // results one byte can cause
    localparam int unsigned Q_DEPTH_DFLT  = 4;  // bundles between front and back

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [1:0] {
        SEC_START   = 2'd0,
        SEC_HEADERS = 2'd1,
        SEC_DONE    = 2'd2,
        SEC_ERROR   = 2'd3
    } t_section;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_METHOD    = 3'd1,
        KIND_TARGET    = 3'd2,
        KIND_VERSION   = 3'd3,
        KIND_STATUS    = 3'd4,
        KIND_HDR_NAME  = 3'd5,
        KIND_HDR_VALUE = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        EV_DATA       = 3'd0,
        EV_FIELD_DONE = 3'd1,
        EV_HEAD_END   = 3'd2,
        EV_ERROR      = 3'd3,
        EV_INCOMPLETE = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_event     ev;
    } t_result;

    // All results caused by one input byte; last is the index of the final one.
    typedef struct packed {
        t_result [RES_SLOTS-1:0] res;
        logic [1:0]              last;
    } t_bundle;

    // True when the current start-line field runs to the end of the line.
    function automatic logic last_start_field(input logic [1:0] fi, input logic mode);
        last_start_field = mode ? (fi >= 2'd1) : (fi >= 2'd2);
    endfunction

    function automatic t_kind current_kind(input t_section sec, input logic [1:0] fi,
                                           input logic mode);
        t_kind k;
        if (sec == SEC_START) begin
            if (mode) begin
                k = (fi == 2'd0) ? KIND_VERSION : KIND_STATUS;
            end else if (fi >= 2'd2) begin
                k = KIND_VERSION;
            end else begin
                k = (fi == 2'd0) ? KIND_METHOD : KIND_TARGET;
            end
        end else begin
            k = (fi != 2'd0) ? KIND_HDR_VALUE : KIND_HDR_NAME;
        end
        return k;
    endfunction

endpackage

### design/hsp_front.sv
// hsp_front: parse state machine. Classifies each accepted byte and builds
// the bundle of results it causes. Depends on hsp_pkg.
module hsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first_of_message,
    input  logic            i_end_of_data,
    output hsp_pkg::t_bundle o_bundle,
    output logic            o_bundle_valid
);
    import hsp_pkg::*;

    t_section   r_section, n_section;
    logic [1:0] r_field_index, n_field_index;
    logic       r_held_cr, n_held_cr;
    logic       r_held_colon, n_held_colon;
    logic       r_at_line_start, n_at_line_start;
    logic       r_parse_mode;

    // state as seen by this byte (after an optional restart)
    t_section   e_sec;
    logic [1:0] e_fi;
    logic       e_hcr, e_hcol, e_als, active;
    t_kind      kind;

    // classification
    logic le, cr_pre, cs, col_pre, rest, hold_cr, delim, hold_col, data;
    logic le_ok_start, le_end, le_val, le_err, incomplete;

    t_bundle    bundle;
    logic [1:0] cnt;

    always_comb begin
        if (i_first_of_message) begin
            e_sec  = SEC_START;
            e_fi   = 2'd0;
            e_hcr  = 1'b0;
            e_hcol = 1'b0;
            e_als  = 1'b1;
        end else begin
            e_sec  = r_section;
            e_fi   = r_field_index;
            e_hcr  = r_held_cr;
            e_hcol = r_held_colon;
            e_als  = r_at_line_start;
        end
        active = (e_sec == SEC_START) || (e_sec == SEC_HEADERS);
        kind   = current_kind(e_sec, e_fi, r_parse_mode);
    end

    always_comb begin
        le       = active && e_hcr && (i_data_byte == CHAR_LF);
        cr_pre   = active && e_hcr && !le;
        cs       = active && !le && e_hcol && (i_data_byte == CHAR_SP);
        col_pre  = active && !le && e_hcol && (i_data_byte != CHAR_SP);
        rest     = active && !le && !cs;
        hold_cr  = rest && (i_data_byte == CHAR_CR);
        delim    = rest && !hold_cr && (e_sec == SEC_START) && (i_data_byte == CHAR_SP)
                   && !last_start_field(e_fi, r_parse_mode);
        hold_col = rest && !hold_cr && (e_sec == SEC_HEADERS) && (e_fi == 2'd0)
                   && (i_data_byte == CHAR_COLON);
        data     = rest && !hold_cr && !delim && !hold_col;

        le_ok_start = le && (e_sec == SEC_START) && last_start_field(e_fi, r_parse_mode);
        le_end      = le && (e_sec == SEC_HEADERS) && e_als;
        le_val      = le && (e_sec == SEC_HEADERS) && !e_als && (e_fi != 2'd0);
        le_err      = le && !le_ok_start && !le_end && !le_val;
        incomplete  = active && i_end_of_data && !le_end && !le_err;
    end

    // next state
    always_comb begin
        n_section       = e_sec;
        n_field_index   = e_fi;
        n_held_cr       = e_hcr;
        n_held_colon    = e_hcol;
        n_at_line_start = e_als;
        if (active) begin
            n_held_cr    = hold_cr;
            n_held_colon = hold_col;
            if (le_ok_start) begin
                n_section = SEC_HEADERS;
            end else if (le_end) begin
                n_section = SEC_DONE;
            end else if (le_err) begin
                n_section = SEC_ERROR;
            end
            if (le_ok_start || le_val) begin
                n_field_index   = 2'd0;
                n_at_line_start = 1'b1;
            end else if (cs) begin
                n_field_index = 2'd1;
            end else if (delim) begin
                n_field_index = e_fi + 2'd1;
            end
            if (cr_pre || hold_col || data) begin
                n_at_line_start = 1'b0;
            end
        end
    end

    // result bundle
    always_comb begin
        bundle = '0;
        cnt    = 2'd0;
        if (cr_pre) begin
            bundle.res[cnt] = '{data: CHAR_CR, kind: kind, ev: EV_DATA};
            cnt = cnt + 2'd1;
        end
        if (col_pre) begin
            bundle.res[cnt] = '{data: CHAR_COLON, kind: kind, ev: EV_DATA};
            cnt = cnt + 2'd1;
        end
        if (le_ok_start || le_val || cs || delim) begin
            bundle.res[cnt] = '{data: 8'h00, kind: kind, ev: EV_FIELD_DONE};
            cnt = cnt + 2'd1;
        end else if (le_end) begin
            bundle.res[cnt] = '{data: 8'h00, kind: KIND_NONE, ev: EV_HEAD_END};
            cnt = cnt + 2'd1;
        end else if (le_err) begin
            bundle.res[cnt] = '{data: 8'h00, kind: KIND_NONE, ev: EV_ERROR};
            cnt = cnt + 2'd1;
        end else if (data) begin
            bundle.res[cnt] = '{data: i_data_byte, kind: kind, ev: EV_DATA};
            cnt = cnt + 2'd1;
        end
        if (incomplete) begin
            bundle.res[cnt] = '{data: 8'h00, kind: KIND_NONE, ev: EV_INCOMPLETE};
            cnt = cnt + 2'd1;
        end
        bundle.last = cnt - 2'd1;
    end

    assign o_bundle       = bundle;
    assign o_bundle_valid = (cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_parse_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section       <= SEC_START;
            r_field_index   <= 2'd0;
            r_held_cr       <= 1'b0;
            r_held_colon    <= 1'b0;
            r_at_line_start <= 1'b1;
        end else if (i_accept) begin
            r_section       <= n_section;
            r_field_index   <= n_field_index;
            r_held_cr       <= n_held_cr;
            r_held_colon    <= n_held_colon;
            r_at_line_start <= n_at_line_start;
        end
    end

    // a held CR and a held colon exclude each other
    a_hold_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_held_cr && r_held_colon))
        else $error("held CR and held colon both set");

    // an accepted field delimiter always advances the field index
    a_delim_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && delim) |=> (r_field_index == $past(e_fi) + 2'd1))
        else $error("start-line delimiter did not advance field index");

endmodule

### design/hsp_queue.sv
// hsp_queue: short queue of result bundles between the parse front and the
// result back end. Depends on hsp_pkg.
module hsp_queue #(
    parameter int unsigned DEPTH = hsp_pkg::Q_DEPTH_DFLT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  hsp_pkg::t_bundle i_wr_data,
    input  logic             i_rd_en,
    output hsp_pkg::t_bundle o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    import hsp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !o_full)
        else $error("bundle queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> !o_empty)
        else $error("bundle queue read while empty");

endmodule

### design/hsp_back.sv
// hsp_back: takes bundles from the queue and hands out their results one per
// transfer on the empty/pop side. Depends on hsp_pkg.
module hsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  hsp_pkg::t_bundle i_q_data,
    output logic             o_q_rd,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_field_kind,
    output logic [2:0]       o_event_res,
    output logic             o_last_of_run
);
    import hsp_pkg::*;

    t_bundle    r_bundle;
    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic       take, done_cur, load;
    t_result    cur;

    assign cur      = r_bundle.res[r_idx];
    assign take     = pop && r_valid;
    assign done_cur = take && (r_idx == r_bundle.last);
    assign load     = (!r_valid || done_cur) && !i_q_empty;
    assign o_q_rd   = load;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (done_cur) begin
            n_valid = 1'b0;
        end else if (take) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bundle <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign empty         = !r_valid;
    assign o_out_byte    = cur.data;
    assign o_field_kind  = cur.kind;
    assign o_event_res   = cur.ev;
    assign o_last_of_run = (r_idx == r_bundle.last);

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_bundle.last))
        else $error("result index past end of bundle");

endmodule

### design/http_start_line_header_parser.sv
// http_start_line_header_parser: top level of the streaming HTTP head parser.
// Instantiates hsp_front, hsp_queue and hsp_back; depends on hsp_pkg.
//
// Usage:
//  - Input side is a queue write port: a byte transfers on a rising edge with
//    push high and full low. first_of_message restarts the parse at the start
//    line before the byte; end_of_data adds an incomplete result if the head
//    has not finished.
//  - Result side is a queue read port: while empty is low the oldest result
//    sits on o_out_byte/o_field_kind/o_event_res/o_last_of_run and transfers
//    on a rising edge with pop high. o_last_of_run closes the results of one
//    input byte; a byte may cause zero to three results.
//  - i_cfg_wr_en/i_cfg_wr_data write parse_mode (0 request, 1 response); write
//    it only while no results are outstanding.
//  - Flow: when drained, a result's bundle passes its queue entry and then
//    the back-end bundle register on its way to the result ports. Input
//    takes one byte per cycle while full is low; the output drains one result
//    per cycle while pop is high; a bundle stays until all results are popped.
//  - The front parses each byte in its cycle and pushes its result bundle
//    into a QUEUE_DEPTH-entry queue; the back end holds one more bundle. full
//    rises when that queue is full, i.e. when the receiver stalls long enough.
//    Bytes that cause no result are also held off while full.
//  - Reset (synchronous, active low) returns the parse to the start line,
//    clears parse_mode and empties the queue and output stage.
module http_start_line_header_parser #(
    parameter int unsigned QUEUE_DEPTH = hsp_pkg::Q_DEPTH_DFLT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_message,
    input  logic       i_end_of_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_field_kind,
    output logic [2:0] o_event_res,
    output logic       o_last_of_run
);
    import hsp_pkg::*;

    logic    accept;
    t_bundle fr_bundle;
    logic    fr_valid;
    t_bundle q_data;
    logic    q_empty, q_full, q_rd;

    // Byte transfer; the parse state advances on every transfer.
    assign accept = push && !q_full;
    assign full   = q_full;

    hsp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_first_of_message (i_first_of_message),
        .i_end_of_data      (i_end_of_data),
        .o_bundle           (fr_bundle),
        .o_bundle_valid     (fr_valid)
    );

    // Only bytes that produce results occupy a queue entry.
    hsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && fr_valid),
        .i_wr_data (fr_bundle),
        .i_rd_en   (q_rd),
        .o_rd_data (q_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    hsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_data),
        .o_q_rd        (q_rd),
        .pop           (pop),
        .empty         (empty),
        .o_out_byte    (o_out_byte),
        .o_field_kind  (o_field_kind),
        .o_event_res   (o_event_res),
        .o_last_of_run (o_last_of_run)
    );

endmodule
